>>> rtl/core/tfns_pkg.sv
// Shared constants for the triangle face normal setup pipeline.
`default_nettype none

package tfns_pkg;

   // Default widths of the packed coordinate, normal and slot fields.
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int NORMAL_WIDTH_DEF = 16;
   localparam int SLOT_WIDTH_DEF   = 20;

   // Fixed widths of the slot and material fields on the streams.
   localparam int SLOT_FIELD_W = 20;
   localparam int MATERIAL_W   = 16;

   // Cross product magnitudes are scaled to below 2^MAG_WIDTH before squaring.
   localparam int MAG_WIDTH  = 30;
   localparam int SUM_WIDTH  = 2 * MAG_WIDTH + 2;
   localparam int ROOT_WIDTH = MAG_WIDTH + 1;

   // Bit positions of the result flags in rsp_tuser.
   localparam int FLAG_FLIP  = 0;
   localparam int FLAG_DEGEN = 1;
   localparam int FLAG_W     = 2;

endpackage

`default_nettype wire

>>> rtl/core/tfns_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module tfns_isqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [tfns_pkg::SUM_WIDTH-1:0]   in_sum,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   output logic [tfns_pkg::ROOT_WIDTH-1:0]  out_root,
   output logic [SIDE_W-1:0]                out_side
);
   import tfns_pkg::*;

   localparam int REM_W = ROOT_WIDTH + 3;

   logic [REM_W-1:0]      rem_ff  [ROOT_WIDTH];
   logic [REM_W-1:0]      rem_in  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_in [ROOT_WIDTH];
   logic [SUM_WIDTH-1:0]  sum_ff  [ROOT_WIDTH];
   logic [SUM_WIDTH-1:0]  sum_in  [ROOT_WIDTH];
   logic [SIDE_W-1:0]     side_ff [ROOT_WIDTH];
   logic [SIDE_W-1:0]     side_in [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] vld_ff;
   logic [ROOT_WIDTH-1:0] vld_in;

   // Each stage brings down two bits of the radicand and decides one root bit.
   always_comb begin
      logic [REM_W-1:0]      rp;
      logic [REM_W-1:0]      rsh;
      logic [REM_W-1:0]      tr;
      logic [ROOT_WIDTH-1:0] op;
      logic [SUM_WIDTH-1:0]  sp;
      logic                  ge;
      vld_in = {vld_ff[ROOT_WIDTH-2:0], in_valid};
      for (int i = 0; i < ROOT_WIDTH; i++) begin
         if (i == 0) begin
            rp         = '0;
            op         = '0;
            sp         = in_sum;
            side_in[i] = in_side;
         end else begin
            rp         = rem_ff[i-1];
            op         = root_ff[i-1];
            sp         = sum_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         rsh        = {rp[REM_W-3:0], sp[SUM_WIDTH-1 -: 2]};
         tr         = {(REM_W-2)'(op), 2'b01};
         ge         = (rsh >= tr);
         rem_in[i]  = ge ? (rsh - tr) : rsh;
         root_in[i] = {op[ROOT_WIDTH-2:0], ge};
         sum_in[i]  = {sp[SUM_WIDTH-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         sum_ff  <= sum_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[ROOT_WIDTH-1];
   assign out_root  = root_ff[ROOT_WIDTH-1];
   assign out_side  = side_ff[ROOT_WIDTH-1];

endmodule

`default_nettype wire

>>> rtl/core/tfns_div.sv
// Pipelined three-lane restoring divider sharing one divisor, one quotient bit per stage.
`default_nettype none

module tfns_div #(
   parameter int FRAC_W = 14,
   parameter int SIDE_W = 8,
   localparam int NUM_W  = tfns_pkg::MAG_WIDTH + FRAC_W + 1,
   localparam int QUOT_W = FRAC_W + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [3*NUM_W-1:0]               in_num,
   input  logic [tfns_pkg::ROOT_WIDTH-1:0]  in_den,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   output logic [3*QUOT_W-1:0]              out_quot,
   output logic [SIDE_W-1:0]                out_side
);
   import tfns_pkg::*;

   logic [ROOT_WIDTH-1:0] rem_ff  [QUOT_W][3];
   logic [ROOT_WIDTH-1:0] rem_in  [QUOT_W][3];
   logic [QUOT_W-1:0]     lo_ff   [QUOT_W][3];
   logic [QUOT_W-1:0]     lo_in   [QUOT_W][3];
   logic [ROOT_WIDTH-1:0] den_ff  [QUOT_W];
   logic [ROOT_WIDTH-1:0] den_in  [QUOT_W];
   logic [SIDE_W-1:0]     side_ff [QUOT_W];
   logic [SIDE_W-1:0]     side_in [QUOT_W];
   logic [QUOT_W-1:0]     vld_ff;
   logic [QUOT_W-1:0]     vld_in;

   // The quotient is known to fit QUOT_W bits, so the upper numerator bits
   // start as the partial remainder. The low register shifts numerator bits
   // out and quotient bits in.
   always_comb begin
      logic [ROOT_WIDTH-1:0] rp;
      logic [QUOT_W-1:0]     lp;
      logic [ROOT_WIDTH-1:0] dp;
      logic [ROOT_WIDTH:0]   t;
      logic                  ge;
      vld_in = {vld_ff[QUOT_W-2:0], in_valid};
      for (int i = 0; i < QUOT_W; i++) begin
         if (i == 0) begin
            dp         = in_den;
            side_in[i] = in_side;
         end else begin
            dp         = den_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         den_in[i] = dp;
         for (int j = 0; j < 3; j++) begin
            if (i == 0) begin
               rp = ROOT_WIDTH'(in_num[j*NUM_W+QUOT_W +: MAG_WIDTH]);
               lp = in_num[j*NUM_W +: QUOT_W];
            end else begin
               rp = rem_ff[i-1][j];
               lp = lo_ff[i-1][j];
            end
            t           = {rp, lp[QUOT_W-1]};
            ge          = (t >= {1'b0, dp});
            rem_in[i][j] = ge ? ROOT_WIDTH'(t - {1'b0, dp}) : ROOT_WIDTH'(t);
            lo_in[i][j]  = {lp[QUOT_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         lo_ff   <= lo_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[QUOT_W-1];
   assign out_quot  = {lo_ff[QUOT_W-1][2], lo_ff[QUOT_W-1][1], lo_ff[QUOT_W-1][0]};
   assign out_side  = side_ff[QUOT_W-1];

endmodule

`default_nettype wire

>>> rtl/core/triangle_face_normal_setup.sv
// Top level of the triangle face normal setup pipeline.
`default_nettype none

// Channel | Direction | Handshake         | Contents
// req     | in        | tvalid / tready   | one gathered triangle per beat
// rsp     | out       | tvalid / tready   | unit face normal and flags per beat
//
// One beat is accepted every cycle while the output buffer has room.
// Seven setup stages, 31 square root stages, a rounding stage, NORMAL_WIDTH-1
// divider stages, three orientation stages and the output buffer lie in order.
// Reset is synchronous and clears the valid bits and the output buffer.
// A stalled output holds the whole pipeline; the two-entry output buffer keeps
// rsp_tready off the path to req_tready.

module triangle_face_normal_setup #(
   parameter int COORD_WIDTH  = tfns_pkg::COORD_WIDTH_DEF,
   parameter int NORMAL_WIDTH = tfns_pkg::NORMAL_WIDTH_DEF,
   parameter int SLOT_WIDTH   = tfns_pkg::SLOT_WIDTH_DEF,
   localparam int REQ_W = ((tfns_pkg::SLOT_FIELD_W + 9*COORD_WIDTH + 9*NORMAL_WIDTH
                            + tfns_pkg::MATERIAL_W + 7) / 8) * 8,
   localparam int RSP_W = ((tfns_pkg::SLOT_FIELD_W + 3*NORMAL_WIDTH
                            + tfns_pkg::MATERIAL_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tri_slot, corner_a, corner_b, corner_c, vnorm_a, vnorm_b, vnorm_c, material_id
   input  logic [REQ_W-1:0]              req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // slot_out, face_normal, material_out
   output logic [RSP_W-1:0]              rsp_tdata,
   // was_flipped, degenerate
   output logic [tfns_pkg::FLAG_W-1:0]   rsp_tuser
);
   import tfns_pkg::*;

   localparam int DW       = COORD_WIDTH + 1;
   localparam int PROD_W   = 2 * DW;
   localparam int CPW      = 2 * DW + 1;
   localparam int FRAC_W   = NORMAL_WIDTH - 2;
   localparam int QUOT_W   = FRAC_W + 1;
   localparam int NUM_W    = MAG_WIDTH + FRAC_W + 1;
   localparam int EXTRA_W  = (CPW > MAG_WIDTH) ? (CPW - MAG_WIDTH) : 0;
   localparam int SH_W     = (EXTRA_W > 0) ? $clog2(EXTRA_W + 1) : 1;
   localparam int KEEP_W   = (SLOT_WIDTH < SLOT_FIELD_W) ? SLOT_WIDTH : SLOT_FIELD_W;
   localparam int VN_W     = 9 * NORMAL_WIDTH;
   localparam int PASS_W   = VN_W + KEEP_W + MATERIAL_W;
   localparam int SQ_SIDE_W = PASS_W + 4 + 3*MAG_WIDTH;
   localparam int DV_SIDE_W = PASS_W + 4;
   localparam int DOT_W    = 2*NORMAL_WIDTH + 2;
   localparam int OFS_A    = SLOT_FIELD_W;
   localparam int OFS_B    = OFS_A + 3*COORD_WIDTH;
   localparam int OFS_C    = OFS_B + 3*COORD_WIDTH;
   localparam int OFS_VN   = OFS_C + 3*COORD_WIDTH;
   localparam int OFS_MAT  = OFS_VN + VN_W;
   localparam int OFS_NRM  = SLOT_FIELD_W;
   localparam int OFS_OMAT = OFS_NRM + 3*NORMAL_WIDTH;
   localparam int ENT_W    = RSP_W + FLAG_W;

   // Global advance: the pipeline moves whenever the output buffer is not full.
   logic en;
   logic [1:0] count_ff;
   assign en         = (count_ff != 2'd2);
   assign req_tready = en;

   // Setup valid bits, one per stage s1..s7.
   logic [6:0] vld_ff;

   // Stage 1: edge vectors.
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e1_in [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] e2_in [3];
   logic [PASS_W-1:0]    s1_pass_ff;
   logic [PASS_W-1:0]    s1_pass_in;

   always_comb begin
      logic signed [COORD_WIDTH-1:0] ca;
      logic signed [COORD_WIDTH-1:0] cb;
      logic signed [COORD_WIDTH-1:0] cc;
      for (int j = 0; j < 3; j++) begin
         ca       = signed'(req_tdata[OFS_A + j*COORD_WIDTH +: COORD_WIDTH]);
         cb       = signed'(req_tdata[OFS_B + j*COORD_WIDTH +: COORD_WIDTH]);
         cc       = signed'(req_tdata[OFS_C + j*COORD_WIDTH +: COORD_WIDTH]);
         e1_in[j] = DW'(cb) - DW'(ca);
         e2_in[j] = DW'(cc) - DW'(ca);
      end
      s1_pass_in = {req_tdata[OFS_MAT +: MATERIAL_W], req_tdata[KEEP_W-1:0],
                    req_tdata[OFS_VN +: VN_W]};
   end

   // Stage 2: the six partial products of the cross product.
   logic signed [PROD_W-1:0] pr_ff [6];
   logic signed [PROD_W-1:0] pr_in [6];
   logic [PASS_W-1:0]        s2_pass_ff;

   always_comb begin
      pr_in[0] = PROD_W'(e1_ff[1]) * PROD_W'(e2_ff[2]);
      pr_in[1] = PROD_W'(e1_ff[2]) * PROD_W'(e2_ff[1]);
      pr_in[2] = PROD_W'(e1_ff[2]) * PROD_W'(e2_ff[0]);
      pr_in[3] = PROD_W'(e1_ff[0]) * PROD_W'(e2_ff[2]);
      pr_in[4] = PROD_W'(e1_ff[0]) * PROD_W'(e2_ff[1]);
      pr_in[5] = PROD_W'(e1_ff[1]) * PROD_W'(e2_ff[0]);
   end

   // Stage 3: cross product components.
   logic signed [CPW-1:0] cp_ff [3];
   logic signed [CPW-1:0] cp_in [3];
   logic [PASS_W-1:0]     s3_pass_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         cp_in[j] = CPW'(pr_ff[2*j]) - CPW'(pr_ff[2*j+1]);
      end
   end

   // Stage 4: magnitudes, signs, and the shift that brings the largest
   // magnitude below 2^MAG_WIDTH. The top set bit of the OR of the
   // magnitudes is the top set bit of their maximum.
   logic [CPW-1:0]  mag_ff [3];
   logic [CPW-1:0]  mag_in [3];
   logic [2:0]      neg_s4_ff;
   logic [2:0]      neg_s4_in;
   logic [SH_W-1:0] sh_ff;
   logic [SH_W-1:0] sh_in;
   logic            degen_s4_ff;
   logic            degen_s4_in;
   logic [PASS_W-1:0] s4_pass_ff;

   always_comb begin
      logic [CPW-1:0] or_all;
      for (int j = 0; j < 3; j++) begin
         neg_s4_in[j] = cp_ff[j][CPW-1];
         mag_in[j]    = neg_s4_in[j] ? CPW'(-cp_ff[j]) : CPW'(cp_ff[j]);
      end
      or_all      = mag_in[0] | mag_in[1] | mag_in[2];
      degen_s4_in = (or_all == '0);
      sh_in       = '0;
      for (int k = 0; k < EXTRA_W; k++) begin
         if (or_all[MAG_WIDTH + k]) begin
            sh_in = SH_W'(k + 1);
         end
      end
   end

   // Stage 5: scaled magnitudes.
   logic [MAG_WIDTH-1:0] q_s5_ff [3];
   logic [MAG_WIDTH-1:0] q_s5_in [3];
   logic [2:0]           neg_s5_ff;
   logic                 degen_s5_ff;
   logic [PASS_W-1:0]    s5_pass_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         q_s5_in[j] = MAG_WIDTH'(mag_ff[j] >> sh_ff);
      end
   end

   // Stage 6: squares.
   logic [2*MAG_WIDTH-1:0] sq_ff [3];
   logic [2*MAG_WIDTH-1:0] sq_in [3];
   logic [MAG_WIDTH-1:0]   q_s6_ff [3];
   logic [2:0]             neg_s6_ff;
   logic                   degen_s6_ff;
   logic [PASS_W-1:0]      s6_pass_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sq_in[j] = (2*MAG_WIDTH)'(q_s5_ff[j]) * (2*MAG_WIDTH)'(q_s5_ff[j]);
      end
   end

   // Stage 7: sum of squares.
   logic [SUM_WIDTH-1:0] sum_ff;
   logic [SUM_WIDTH-1:0] sum_in;
   logic [MAG_WIDTH-1:0] q_s7_ff [3];
   logic [2:0]           neg_s7_ff;
   logic                 degen_s7_ff;
   logic [PASS_W-1:0]    s7_pass_ff;

   assign sum_in = SUM_WIDTH'(sq_ff[0]) + SUM_WIDTH'(sq_ff[1]) + SUM_WIDTH'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff       <= e1_in;
         e2_ff       <= e2_in;
         s1_pass_ff  <= s1_pass_in;
         pr_ff       <= pr_in;
         s2_pass_ff  <= s1_pass_ff;
         cp_ff       <= cp_in;
         s3_pass_ff  <= s2_pass_ff;
         mag_ff      <= mag_in;
         neg_s4_ff   <= neg_s4_in;
         sh_ff       <= sh_in;
         degen_s4_ff <= degen_s4_in;
         s4_pass_ff  <= s3_pass_ff;
         q_s5_ff     <= q_s5_in;
         neg_s5_ff   <= neg_s4_ff;
         degen_s5_ff <= degen_s4_ff;
         s5_pass_ff  <= s4_pass_ff;
         sq_ff       <= sq_in;
         q_s6_ff     <= q_s5_ff;
         neg_s6_ff   <= neg_s5_ff;
         degen_s6_ff <= degen_s5_ff;
         s6_pass_ff  <= s5_pass_ff;
         sum_ff      <= sum_in;
         q_s7_ff     <= q_s6_ff;
         neg_s7_ff   <= neg_s6_ff;
         degen_s7_ff <= degen_s6_ff;
         s7_pass_ff  <= s6_pass_ff;
      end
   end

   // Length of the scaled cross product.
   logic                  sq_vld;
   logic [ROOT_WIDTH-1:0] sq_root;
   logic [SQ_SIDE_W-1:0]  sq_side;

   tfns_isqrt #(
      .SIDE_W (SQ_SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_ff[6]),
      .in_sum    (sum_ff),
      .in_side   ({s7_pass_ff, neg_s7_ff, degen_s7_ff, q_s7_ff[2], q_s7_ff[1], q_s7_ff[0]}),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Rounding stage: numerator q * 2^F + L/2, divisor L (never zero).
   logic                  rnd_vld_ff;
   logic [3*NUM_W-1:0]    num_ff;
   logic [3*NUM_W-1:0]    num_in;
   logic [ROOT_WIDTH-1:0] den_ff;
   logic [ROOT_WIDTH-1:0] den_in;
   logic [DV_SIDE_W-1:0]  rnd_side_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         num_in[j*NUM_W +: NUM_W] = (NUM_W'(sq_side[j*MAG_WIDTH +: MAG_WIDTH]) << FRAC_W)
                                    + NUM_W'(sq_root >> 1);
      end
      den_in = (sq_root == '0) ? ROOT_WIDTH'(1) : sq_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_vld_ff <= 1'b0;
      end else if (en) begin
         rnd_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff      <= num_in;
         den_ff      <= den_in;
         rnd_side_ff <= sq_side[SQ_SIDE_W-1 -: DV_SIDE_W];
      end
   end

   logic                 dv_vld;
   logic [3*QUOT_W-1:0]  dv_quot;
   logic [DV_SIDE_W-1:0] dv_side;

   tfns_div #(
      .FRAC_W (FRAC_W),
      .SIDE_W (DV_SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rnd_vld_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (rnd_side_ff),
      .out_valid (dv_vld),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // Side bundle after the divider: {pass, signs, degenerate}.
   logic              dv_degen;
   logic [2:0]        dv_neg;
   logic [PASS_W-1:0] dv_pass;
   assign dv_degen = dv_side[0];
   assign dv_neg   = dv_side[3:1];
   assign dv_pass  = dv_side[DV_SIDE_W-1 -: PASS_W];

   // Orientation stage 1: signed normal components.
   logic [2:0] post_vld_ff;
   logic signed [NORMAL_WIDTH-1:0] nrm_d1_ff [3];
   logic signed [NORMAL_WIDTH-1:0] nrm_d1_in [3];
   logic                           degen_d1_ff;
   logic [PASS_W-1:0]              d1_pass_ff;

   always_comb begin
      logic [NORMAL_WIDTH-1:0] qm;
      for (int j = 0; j < 3; j++) begin
         qm           = NORMAL_WIDTH'(dv_quot[j*QUOT_W +: QUOT_W]);
         nrm_d1_in[j] = dv_neg[j] ? signed'(-qm) : signed'(qm);
      end
   end

   // Orientation stage 2: the nine products of the three dot products.
   logic signed [2*NORMAL_WIDTH-1:0] dp_ff [9];
   logic signed [2*NORMAL_WIDTH-1:0] dp_in [9];
   logic signed [NORMAL_WIDTH-1:0]   nrm_d2_ff [3];
   logic                             degen_d2_ff;
   logic [PASS_W-KEEP_W-MATERIAL_W+KEEP_W+MATERIAL_W-1:0] d2_pass_ff;

   always_comb begin
      logic signed [NORMAL_WIDTH-1:0] vn;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            vn           = signed'(d1_pass_ff[(k*3 + j)*NORMAL_WIDTH +: NORMAL_WIDTH]);
            dp_in[k*3+j] = (2*NORMAL_WIDTH)'(nrm_d1_ff[j]) * (2*NORMAL_WIDTH)'(vn);
         end
      end
   end

   // Orientation stage 3: signs of the three dot products.
   logic [2:0]                     dneg_ff;
   logic [2:0]                     dneg_in;
   logic signed [NORMAL_WIDTH-1:0] nrm_d3_ff [3];
   logic                           degen_d3_ff;
   logic [PASS_W-1:0]              d3_pass_ff;

   always_comb begin
      logic signed [DOT_W-1:0] dsum;
      for (int k = 0; k < 3; k++) begin
         dsum       = DOT_W'(dp_ff[k*3]) + DOT_W'(dp_ff[k*3+1]) + DOT_W'(dp_ff[k*3+2]);
         dneg_in[k] = dsum[DOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= '0;
      end else if (en) begin
         post_vld_ff <= {post_vld_ff[1:0], dv_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nrm_d1_ff   <= nrm_d1_in;
         degen_d1_ff <= dv_degen;
         d1_pass_ff  <= dv_pass;
         dp_ff       <= dp_in;
         nrm_d2_ff   <= nrm_d1_ff;
         degen_d2_ff <= degen_d1_ff;
         d2_pass_ff  <= d1_pass_ff;
         dneg_ff     <= dneg_in;
         nrm_d3_ff   <= nrm_d2_ff;
         degen_d3_ff <= degen_d2_ff;
         d3_pass_ff  <= d2_pass_ff;
      end
   end

   // Final selection: negate when the normal faces away from all three
   // vertex normals. A degenerate triangle has zero dot products and never
   // flips.
   logic                      flip;
   logic [3*NORMAL_WIDTH-1:0] nrm_pack;
   logic [ENT_W-1:0]          wr_data;

   always_comb begin
      logic signed [NORMAL_WIDTH-1:0] fn;
      flip = &dneg_ff;
      for (int j = 0; j < 3; j++) begin
         fn = flip ? -nrm_d3_ff[j] : nrm_d3_ff[j];
         nrm_pack[j*NORMAL_WIDTH +: NORMAL_WIDTH] = fn;
      end
      wr_data = '0;
      wr_data[SLOT_FIELD_W-1:0]              = SLOT_FIELD_W'(d3_pass_ff[VN_W +: KEEP_W]);
      wr_data[OFS_NRM +: 3*NORMAL_WIDTH]     = nrm_pack;
      wr_data[OFS_OMAT +: MATERIAL_W]        = d3_pass_ff[VN_W + KEEP_W +: MATERIAL_W];
      wr_data[RSP_W + FLAG_FLIP]             = flip;
      wr_data[RSP_W + FLAG_DEGEN]            = degen_d3_ff;
   end

   // Two-entry output buffer.
   logic [ENT_W-1:0] ent_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   assign push     = en & post_vld_ff[2];
   assign pop      = rsp_tvalid & rsp_tready;
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = ent_ff[rd_ptr_ff][RSP_W-1:0];
   assign rsp_tuser  = ent_ff[rd_ptr_ff][RSP_W +: FLAG_W];

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer count out of range");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> req_tready)
      else $error("input stalled with an empty output buffer");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == 2'd0) |=> rsp_tvalid)
      else $error("pushed result not presented");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[FLAG_DEGEN]) |->
         (rsp_tdata[OFS_NRM +: 3*NORMAL_WIDTH] == '0 && !rsp_tuser[FLAG_FLIP]))
      else $error("degenerate result with non-zero normal or flip");

endmodule

`default_nettype wire

>>> tb/triangle_face_normal_setup_test.sv
// Self-checking testbench for the triangle face normal setup pipeline.
`timescale 1ns / 100ps

typedef struct {
   bit [19:0] slot;
   bit [47:0] corner [3];
   bit [47:0] vnorm  [3];
   bit [15:0] material;
} triangle_t;

typedef struct packed {
   bit [19:0] slot;
   bit [47:0] normal;
   bit        flipped;
   bit        degen;
   bit [15:0] material;
} face_t;

// Computes the expected face record for each accepted triangle and checks the
// results against them in order.
class face_scoreboard;
   face_t pending[$];
   int    mismatches;
   int    checked;
   int    degen_seen;
   int    flip_seen;

   static function longint unsigned root_floor(longint unsigned s);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   static function face_t face_of(triangle_t t);
      face_t           f;
      longint          pos [3][3];
      longint          vn  [3][3];
      longint          e1 [3], e2 [3], p [3], nrm [3];
      longint unsigned mag [3];
      longint unsigned mx, sum, len, q;
      longint          d [3];
      bit              neg [3];
      int              sh;
      for (int k = 0; k < 3; k++)
         for (int j = 0; j < 3; j++) begin
            pos[k][j] = longint'($signed(t.corner[k][16*j +: 16]));
            vn[k][j]  = longint'($signed(t.vnorm[k][16*j +: 16]));
         end
      for (int j = 0; j < 3; j++) begin
         e1[j] = pos[1][j] - pos[0][j];
         e2[j] = pos[2][j] - pos[0][j];
      end
      p[0] = e1[1] * e2[2] - e1[2] * e2[1];
      p[1] = e1[2] * e2[0] - e1[0] * e2[2];
      p[2] = e1[0] * e2[1] - e1[1] * e2[0];
      mx = 0;
      for (int j = 0; j < 3; j++) begin
         neg[j] = p[j] < 0;
         mag[j] = neg[j] ? longint'(-p[j]) : longint'(p[j]);
         if (mag[j] > mx) mx = mag[j];
         nrm[j] = 0;
      end
      f.slot     = t.slot;
      f.material = t.material;
      f.degen    = (mx == 0);
      f.flipped  = 0;
      if (!f.degen) begin
         // Scale the magnitudes below 2^30 so that the sum of squares fits.
         sh = 0;
         while ((mx >> sh) >= (64'd1 << 30)) sh++;
         sum = 0;
         for (int j = 0; j < 3; j++) begin
            mag[j] >>= sh;
            sum += mag[j] * mag[j];
         end
         len = root_floor(sum);
         if (len == 0) len = 1;
         for (int j = 0; j < 3; j++) begin
            q      = ((mag[j] << 14) + (len >> 1)) / len;
            nrm[j] = neg[j] ? -longint'(q) : longint'(q);
         end
         for (int k = 0; k < 3; k++) begin
            d[k] = 0;
            for (int j = 0; j < 3; j++) d[k] += nrm[j] * vn[k][j];
         end
         if (d[0] < 0 && d[1] < 0 && d[2] < 0) begin
            f.flipped = 1;
            for (int j = 0; j < 3; j++) nrm[j] = -nrm[j];
         end
      end
      for (int j = 0; j < 3; j++) f.normal[16*j +: 16] = nrm[j][15:0];
      return f;
   endfunction

   function void note_triangle(triangle_t t);
      pending.push_back(face_of(t));
   endfunction

   function void check_face(face_t got);
      face_t want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: face beat with no triangle outstanding, slot %h", got.slot);
         return;
      end
      want = pending.pop_front();
      checked++;
      if (want.degen) degen_seen++;
      if (want.flipped) flip_seen++;
      if (got != want) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"ERROR: face %0d expected slot %h normal %h flip %b degen %b mat %h,",
                      " got slot %h normal %h flip %b degen %b mat %h"}, checked,
                     want.slot, want.normal, want.flipped, want.degen, want.material,
                     got.slot, got.normal, got.flipped, got.degen, got.material);
      end
   endfunction
endclass

module triangle_face_normal_setup_test;
   import tfns_pkg::*;

   localparam int REQ_W      = 328;
   localparam int RSP_W      = 88;
   localparam int LATENCY    = 59;
   localparam int CYCLE_CAP  = 600000;
   localparam int RANDOM_CNT = 1230;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [FLAG_W-1:0] rsp_tuser;

   face_scoreboard board;
   int             cycles;
   int             sent;
   bit             req_steady;   // when set, the sender inserts no gaps
   bit             rsp_steady;   // when set, the receiver never stalls

   triangle_face_normal_setup dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Watchdog: the slowest legal run is far below this cap.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("TIMEOUT after %0d cycles", cycles);
         $display("triangle_face_normal_setup verification failed");
         $finish;
      end
   end

   function automatic bit [47:0] vec3(int x, int y, int z);
      vec3 = {z[15:0], y[15:0], x[15:0]};
   endfunction

   function automatic bit [47:0] rand48();
      rand48 = {$urandom, $urandom};
   endfunction

   // Sends one triangle beat, idling for a random number of cycles first.
   task automatic send_triangle(triangle_t t);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, t.material, t.vnorm[2], t.vnorm[1], t.vnorm[0],
                     t.corner[2], t.corner[1], t.corner[0], t.slot};
      do @(posedge clock); while (!req_tready);
      board.note_triangle(t);
      sent++;
   endtask

   task automatic send_shape(bit [47:0] a, bit [47:0] b, bit [47:0] c,
                             bit [47:0] na, bit [47:0] nb, bit [47:0] nc);
      triangle_t t;
      t.slot      = $urandom;
      t.material  = $urandom;
      t.corner[0] = a;
      t.corner[1] = b;
      t.corner[2] = c;
      t.vnorm[0]  = na;
      t.vnorm[1]  = nb;
      t.vnorm[2]  = nc;
      send_triangle(t);
   endtask

   // Random triangle of one of several shapes; vertex normals are often set to
   // agree with or oppose the face so that both flip outcomes are frequent.
   task automatic send_random();
      triangle_t t;
      face_t     f;
      int        shape;
      int        span;
      t.slot     = $urandom;
      t.material = $urandom;
      shape      = $urandom_range(0, 9);
      span       = (shape < 4) ? 16'hffff : ((shape < 7) ? 255 : 7);
      for (int k = 0; k < 3; k++) begin
         t.corner[k] = rand48();
         t.vnorm[k]  = rand48();
         if (span != 16'hffff)
            for (int j = 0; j < 3; j++)
               t.corner[k][16*j +: 16] = t.corner[0][16*j +: 16]
                                          + 16'($urandom_range(0, span)) - 16'(span / 2);
      end
      if (shape == 9) begin
         // Collinear or coincident corners give a zero cross product.
         for (int j = 0; j < 3; j++)
            t.corner[2][16*j +: 16] = t.corner[0][16*j +: 16]
               + 16'($urandom_range(0, 2)) * (t.corner[1][16*j +: 16] - t.corner[0][16*j +: 16]);
      end
      if ($urandom_range(0, 2) != 0) begin
         f = board.face_of(t);
         for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
               t.vnorm[k][16*j +: 16] = (shape[0] ? -16'(f.normal[16*j +: 16])
                                                  : f.normal[16*j +: 16])
                                        + 16'($urandom_range(0, 64)) - 16'd32;
      end
      send_triangle(t);
   endtask

   // Receiver: stalls a random number of cycles before each face beat.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Monitor: every face beat is compared with the oldest outstanding triangle.
   always @(posedge clock) begin
      face_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slot     = rsp_tdata[19:0];
         got.normal   = rsp_tdata[67:20];
         got.material = rsp_tdata[83:68];
         got.flipped  = rsp_tuser[FLAG_FLIP];
         got.degen    = rsp_tuser[FLAG_DEGEN];
         board.check_face(got);
      end
   end

   initial begin
      bit [47:0] up, down;
      board      = new();
      sent       = 0;
      req_steady = 0;
      rsp_steady = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      up   = vec3(0, 0, 16384);
      down = vec3(0, 0, -16384);
      // Directed part: degenerate shapes, axis triangles facing both ways,
      // extreme and wrapping coordinates, and the flip decision in each corner.
      send_shape('0, '0, '0, '0, '0, '0);
      send_shape(vec3(5, 5, 5), vec3(5, 5, 5), vec3(9, 1, 2), up, up, up);
      send_shape(vec3(0, 0, 0), vec3(256, 256, 256), vec3(512, 512, 512), up, up, up);
      send_shape(vec3(0, 0, 0), vec3(256, 0, 0), vec3(0, 256, 0), up, up, up);
      send_shape(vec3(0, 0, 0), vec3(256, 0, 0), vec3(0, 256, 0), down, down, down);
      send_shape(vec3(0, 0, 0), vec3(256, 0, 0), vec3(0, 256, 0), down, down, up);
      send_shape(vec3(0, 0, 0), vec3(256, 0, 0), vec3(0, 256, 0), up, down, down);
      send_shape(vec3(0, 0, 0), vec3(256, 0, 0), vec3(0, 256, 0), down, up, down);
      send_shape(vec3(0, 0, 0), vec3(0, 256, 0), vec3(256, 0, 0), up, up, up);
      send_shape(vec3(0, 0, 0), vec3(0, 0, 1), vec3(0, 1, 0), '0, '0, '0);
      send_shape(vec3(0, 0, 0), vec3(1, 0, 0), vec3(0, 1, 1), '1, '1, '1);
      send_shape(vec3(-32768, -32768, -32768), vec3(32767, -32768, 32767),
                 vec3(-32768, 32767, 32767), vec3(-32768, -32768, -32768),
                 vec3(32767, 32767, 32767), vec3(-32768, 0, 32767));
      send_shape(vec3(32767, 32767, 32767), vec3(-32768, 32767, -32768),
                 vec3(32767, -32768, -32768), '1, '1, '1);
      send_shape(vec3(-32768, 0, 0), vec3(32767, 0, 0), vec3(0, 32767, 0),
                 vec3(0, 0, -32768), vec3(0, 0, -32768), vec3(0, 0, -32768));
      send_shape(vec3(-32768, -32768, 0), vec3(32767, -32768, 0),
                 vec3(-32768, 32767, 0), down, down, down);
      send_shape(vec3(1, 2, 3), vec3(4, 6, 8), vec3(7, 1, -5), rand48(), rand48(), rand48());
      send_shape('1, '0, '1, '1, '0, '1);
      send_shape(vec3(0, 0, 0), vec3(3, 0, 0), vec3(0, 4, 0), up, up, up);

      // Random part, with phases where one or both sides run without gaps.
      for (int i = 0; i < RANDOM_CNT; i++) begin
         if (i % 150 == 0) begin
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
         end
         send_random();
      end
      req_tvalid <= 1'b0;
      rsp_steady = 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      $display("Checked %0d face records from %0d triangles (%0d degenerate, %0d flipped),",
               board.checked, sent, board.degen_seen, board.flip_seen);
      $display("with random gaps and stalls on both streams; %0d mismatches.", board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("triangle_face_normal_setup verification clean");
      end else begin
         $display("triangle_face_normal_setup verification failed");
      end
      $finish;
   end
endmodule
